// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned ROUNDS = 64;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;

  // Top-level sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_RD0   = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_WB    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Padding progress after the last item
  typedef enum logic [3:0] {
    PH_EXTRA = 4'b0001,
    PH_ZERO  = 4'b0010,
    PH_LENLO = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // Control from the sequencer to the schedule unit
  typedef struct packed {
    logic       gen;       // produce one schedule word this cycle
    logic       from_mem;  // word comes from the block buffer read data
    logic [5:0] k_idx;     // index of the word being produced
  } sched_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch_fn(input logic [31:0] e, input logic [31:0] f,
                                        input logic [31:0] g);
    ch_fn = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj_fn(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    maj_fn = (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // Keep the top nb bytes of a partial final word and append the marker byte
  function automatic logic [31:0] pad_word(input logic [31:0] word, input logic [1:0] nb);
    case (nb)
      2'd1:    pad_word = {word[31:24], 8'h80, 16'h0000};
      2'd2:    pad_word = {word[31:16], 8'h80, 8'h00};
      2'd3:    pad_word = {word[31:8], 8'h80};
      default: pad_word = PAD_MARK;
    endcase
  endfunction

endpackage

// ===== design/sha256_ram.sv =====
// ----------------------------------------------------------------------------
// sha256_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// sha256_sched
// Message schedule: 16-word sliding window, emits W[t] + K[t] registered.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  input  logic [31:0]            mem_rdata,
  output logic [31:0]            wk
);
  import sha256_pkg::*;

  // win_r[15] is the newest word, win_r[0] is W[t-16]
  logic [31:0] win_r [BLK_WORDS];
  logic [31:0] wk_r;
  logic [31:0] w_new;

  assign w_new = ctl.from_mem ? mem_rdata
               : win_r[0] + small_sig0(win_r[1]) + win_r[9] + small_sig1(win_r[14]);

  always_ff @(posedge clk) begin
    if (ctl.gen) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLK_WORDS-1] <= w_new;
      wk_r <= w_new + ROUND_K[ctl.k_idx];
    end
  end

  assign wk = wk_r;

endmodule

// ===== design/sha256_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_hash
// SHA-256 message hasher over a stream of big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : message items, one 32-bit word each, first byte in bits 31..24.
//           in_tlast marks the final word; its valid byte count (1..4, values
//           above four count as four, zero adds no bytes) rides in tdata.
//   out_* : eight digest items per message, first hash word first; out_tlast
//           flags the eighth.
// Timing:
//   Words are taken one per cycle into the block buffer RAM while the
//   sequencer is idle. When a 16-word block fills, input stalls while the
//   buffer read is primed, 64 rounds run (one per cycle, set by the single
//   round datapath) and the result is folded into the chaining RAM.
//   After the last item the block writes padding one word per cycle, with
//   one or two compressions along the way; then the digest leaves at one
//   item per cycle while the receiver is ready, through an output register.
// Reset clears the fill count, length and chaining valid bits; the hash
// restarts from the initial values. A stalled receiver holds the digest
// sequence; the next message can be taken while the last digest item waits.
// ----------------------------------------------------------------------------
module sha256_hash (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] message_word, [34:32] valid_bytes
  input  logic        in_tlast,   // last_word
  // digest items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // digest_last
);
  import sha256_pkg::*;

  // control state
  state_t       state_r, state_nxt;
  phase_t       phase_r, phase_nxt;
  logic         fin_r, fin_nxt;          // current block work belongs to message end
  logic [3:0]   fill_r, fill_nxt;        // next slot in the block buffer
  logic [63:0]  len_r, len_nxt;          // message bit length
  logic [5:0]   rnd_r, rnd_nxt;
  logic [3:0]   wb_r, wb_nxt;            // writeback step, 0..8
  logic [2:0]   ocnt_r, ocnt_nxt;
  logic [7:0]   hvld_r, hvld_nxt;        // chaining RAM entry written since start
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_word_r, out_word_nxt;
  logic         out_last_r, out_last_nxt;

  // working variables a..h
  logic [31:0]  v_r   [HASH_WORDS];
  logic [31:0]  v_nxt [HASH_WORDS];

  // input field unpack
  logic [31:0]  in_word;
  logic [2:0]   in_vb;
  logic         in_acc;
  logic [2:0]   in_nb;

  // block buffer port
  logic         blk_we;
  logic [31:0]  blk_wdata;
  logic [3:0]   blk_raddr;
  logic [31:0]  blk_rdata;

  // chaining RAM port
  logic         hc_we;
  logic [2:0]   hc_idx;
  logic [31:0]  hc_rdata;
  logic [31:0]  hc_old;
  logic [31:0]  hc_new;

  // schedule and round
  sched_ctl_t   sctl;
  logic [31:0]  wk;
  logic [31:0]  t1, t2;
  logic         out_step;

  assign in_word = in_tdata[31:0];
  assign in_vb   = in_tdata[34:32];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc  = in_tvalid && in_tready;
  // a word that is not last counts as four bytes
  assign in_nb   = (!in_tlast || in_vb[2]) ? 3'd4 : {1'b0, in_vb[1:0]};

  assign out_step = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // ---- block buffer ----
  assign blk_raddr = (state_r == S_RD0) ? 4'd0
                   : (state_r == S_RD1) ? 4'd1
                   : rnd_r[3:0] + 4'd2;

  sha256_ram #(.WIDTH(32), .DEPTH(BLK_WORDS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (fill_r),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  // ---- schedule unit, runs one word ahead of the rounds ----
  always_comb begin
    sctl.gen      = (state_r == S_RD1) || (state_r == S_ROUND);
    sctl.from_mem = (state_r == S_RD1) || (rnd_r < 6'd15);
    sctl.k_idx    = (state_r == S_RD1) ? 6'd0 : rnd_r + 6'd1;
  end

  sha256_sched u_sched (
    .clk       (clk),
    .ctl       (sctl),
    .mem_rdata (blk_rdata),
    .wk        (wk)
  );

  // ---- chaining RAM: read k at step k, add and write back at step k+1 ----
  assign hc_idx = 3'(wb_r - 4'd1);
  assign hc_we  = (state_r == S_WB) && (wb_r != 4'd0);
  assign hc_old = hvld_r[hc_idx] ? hc_rdata : START_HASH[hc_idx];
  assign hc_new = v_r[0] + hc_old;

  sha256_ram #(.WIDTH(32), .DEPTH(HASH_WORDS)) u_hc_ram (
    .clk   (clk),
    .we    (hc_we),
    .waddr (hc_idx),
    .wdata (hc_new),
    .raddr (wb_r[2:0]),
    .rdata (hc_rdata)
  );

  // ---- round datapath ----
  assign t1 = v_r[7] + big_sig1(v_r[4]) + ch_fn(v_r[4], v_r[5], v_r[6]) + wk;
  assign t2 = big_sig0(v_r[0]) + maj_fn(v_r[0], v_r[1], v_r[2]);

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    fin_nxt       = fin_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    rnd_nxt       = rnd_r;
    wb_nxt        = wb_r;
    ocnt_nxt      = ocnt_r;
    hvld_nxt      = hvld_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    v_nxt         = v_r;
    blk_we        = 1'b0;
    blk_wdata     = in_word;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          blk_we    = 1'b1;
          blk_wdata = (in_tlast && !in_vb[2]) ? pad_word(in_word, in_vb[1:0]) : in_word;
          len_nxt   = len_r + {58'd0, in_nb, 3'd0};
          fill_nxt  = fill_r + 4'd1;
          fin_nxt   = in_tlast;
          if (in_tlast) begin
            phase_nxt = in_vb[2] ? PH_EXTRA : PH_ZERO;
          end
          if (fill_r == 4'd15) begin
            state_nxt = S_RD0;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        blk_we = 1'b1;
        case (phase_r)
          PH_EXTRA: begin
            blk_wdata = PAD_MARK;
            phase_nxt = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill_r == 4'd14) begin
              blk_wdata = len_r[63:32];
              phase_nxt = PH_LENLO;
            end else begin
              blk_wdata = 32'd0;
            end
          end
          PH_LENLO: begin
            blk_wdata = len_r[31:0];
            phase_nxt = PH_DONE;
          end
          default: begin
            blk_we = 1'b0;
          end
        endcase
        if (blk_we) begin
          fill_nxt = fill_r + 4'd1;
          if (fill_r == 4'd15) begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        rnd_nxt   = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'(ROUNDS - 1)) begin
          wb_nxt    = 4'd0;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        wb_nxt = wb_r + 4'd1;
        if (hc_we) begin
          // rotate so that v ends up holding the new chaining value in order
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            v_nxt[i] = v_r[i+1];
          end
          v_nxt[HASH_WORDS-1] = hc_new;
          hvld_nxt[hc_idx] = 1'b1;
        end
        if (wb_r == 4'd8) begin
          if (!fin_r) begin
            state_nxt = S_IDLE;
          end else if (phase_r == PH_DONE) begin
            ocnt_nxt  = 3'd0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (out_step) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = v_r[0];
          out_last_nxt  = (ocnt_r == 3'd7);
          ocnt_nxt      = ocnt_r + 3'd1;
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            v_nxt[i] = v_r[i+1];
          end
          v_nxt[HASH_WORDS-1] = v_r[0];
          if (ocnt_r == 3'd7) begin
            // message done: back to the initial hash
            v_nxt     = START_HASH;
            hvld_nxt  = 8'd0;
            len_nxt   = 64'd0;
            fin_nxt   = 1'b0;
            phase_nxt = PH_ZERO;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_ZERO;
      fin_r       <= 1'b0;
      fill_r      <= 4'd0;
      len_r       <= 64'd0;
      rnd_r       <= 6'd0;
      wb_r        <= 4'd0;
      ocnt_r      <= 3'd0;
      hvld_r      <= 8'd0;
      out_valid_r <= 1'b0;
      v_r         <= START_HASH;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rnd_r       <= rnd_nxt;
      wb_r        <= wb_nxt;
      ocnt_r      <= ocnt_nxt;
      hvld_r      <= hvld_nxt;
      out_valid_r <= out_valid_nxt;
      v_r         <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

  // ---- checks ----
  // compression starts only right after the buffer wrapped
  a_rd_after_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD0) |-> (fill_r == 4'd0))
    else $error("compression started on a partial block");

  // the block buffer is not written while a compression reads it
  a_no_wr_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    blk_we |-> (state_r == S_IDLE || state_r == S_PAD))
    else $error("block buffer written during compression");

  // after the last round the fold into the chaining RAM follows
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'(ROUNDS - 1)) |=> (state_r == S_WB))
    else $error("round count overrun");

  // digest leaves only on a block boundary with padding complete
  a_out_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (fill_r == 4'd0 && phase_r == PH_DONE && fin_r))
    else $error("digest emitted before padding finished");

endmodule

// ===== tb/tb_sha256_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_hash
// Streams messages into the hasher and checks each digest item against a
// behavioral SHA-256 model. A short directed table comes first: the empty
// message, "abc", final-word byte counts zero to four and the padding spill into an
// extra block. Random messages with random flow control on both sides follow.
// ----------------------------------------------------------------------------
module tb_sha256_hash;

  localparam int          RAND_ITEMS     = 290;
  localparam int          LONG_HOLD      = 500;   // receiver hold-off, cycles
  localparam int          SETTLE_CYCLES  = 100;   // quiet time after last digest
  localparam int          WATCHDOG_LIMIT = 3000;  // cycles with no handshake
  localparam logic [31:0] MARK_WORD      = 32'h8000_0000;
  localparam logic [31:0] MARK_BYTE      = 32'h0000_0080;

  // Published digests, first word in the top bits
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One directed row: the word is sent reps times in a row
  typedef struct packed {
    logic [31:0]  word;
    logic [2:0]   nbytes;
    logic         last;
    logic [7:0]   reps;
    logic         pinned;   // digest below is the known answer
    logic [255:0] digest;
  } dir_row_t;

  localparam int DIR_ROWS = 11;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty message: zero valid bytes, word content dropped
    '{32'hdeadbeef, 3'd0, 1'b1, 8'd1,  1'b1, EMPTY_DIGEST},
    // "abc", low byte must be masked off
    '{32'h616263ff, 3'd3, 1'b1, 8'd1,  1'b1, ABC_DIGEST},
    '{32'hffffffff, 3'd4, 1'b1, 8'd1,  1'b0, 256'h0},
    // counts above four behave as four
    '{32'h00000000, 3'd7, 1'b1, 8'd1,  1'b0, 256'h0},
    '{32'h12345678, 3'd5, 1'b1, 8'd1,  1'b0, 256'h0},
    '{32'h89abcdef, 3'd1, 1'b1, 8'd1,  1'b0, 256'h0},
    '{32'hfffe0001, 3'd2, 1'b1, 8'd1,  1'b0, 256'h0},
    // non-final words ignore the byte count; marker lands in slot 14,
    // so padding spills into a second block
    '{32'h0f0f0f0f, 3'd1, 1'b0, 8'd13, 1'b0, 256'h0},
    '{32'h5a5a5a5a, 3'd4, 1'b1, 8'd1,  1'b0, 256'h0},
    // message ending on a word boundary via a zero-count final word
    '{32'hc3c3c3c3, 3'd6, 1'b0, 8'd2,  1'b0, 256'h0},
    '{32'hffffffff, 3'd0, 1'b1, 8'd1,  1'b0, 256'h0}
  };

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [31:0] message_word, [34:32] valid_bytes
  logic        in_tlast;   // last_word
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic        out_tlast;  // digest_last

  // Model state
  logic [31:0] chain_words [8];
  logic [31:0] blk_words   [16];
  logic [3:0]  blk_fill;
  logic [63:0] msg_bits;

  digest_item_t digest_q [$];
  int           error_count = 0;
  int           items_sent  = 0;
  int           idle_cycles = 0;
  bit           start_long_hold = 1'b0;

  sha256_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Hash model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    int i;
    for (i = 0; i < 8; i++) chain_words[i] = INIT_HASH[i];
    for (i = 0; i < 16; i++) blk_words[i] = '0;
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  // 64 rounds over the buffered block, folded into the chaining words
  function automatic void hash_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk_words[i];
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (i = 0; i < 8; i++) v[i] = chain_words[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
  endfunction

  function automatic void blk_push(input logic [31:0] w);
    blk_words[blk_fill] = w;
    blk_fill = blk_fill + 4'd1;
    if (blk_fill == 4'd0) hash_compress();
  endfunction

  // Absorb one accepted item; a final word pads, finishes and queues the digest
  function automatic void hash_absorb(input logic [31:0] w, input logic [2:0] nb,
                                      input logic last, input logic pinned,
                                      input logic [255:0] pinned_digest);
    int unsigned n;
    logic [31:0] keep;
    digest_item_t item;
    int k;
    if (!last) begin
      msg_bits = msg_bits + 64'd32;
      blk_push(w);
      return;
    end
    n = (nb > 3'd4) ? 4 : nb;
    msg_bits = msg_bits + 64'(8 * n);
    if (n == 4) begin
      blk_push(w);
      blk_push(MARK_WORD);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      blk_push((w & keep) | (MARK_BYTE << (24 - 8 * n)));
    end
    // no room for the length: close this block with zeros
    if (blk_fill > 4'd14) begin
      while (blk_fill != 4'd0) blk_push(32'h0);
    end
    while (blk_fill < 4'd14) blk_push(32'h0);
    blk_push(msg_bits[63:32]);
    blk_push(msg_bits[31:0]);
    for (k = 0; k < 8; k++) begin
      item.word = pinned ? pinned_digest[255 - 32 * k -: 32] : chain_words[k];
      item.last = (k == 7);
      digest_q.insert(digest_q.size(), item);
    end
    hash_restart();
  endfunction

  // --------------------------------------------------------------------------
  // Flow control helpers
  // --------------------------------------------------------------------------
  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one item, wait for the handshake, update the model, then maybe idle.
  // tvalid stays high across back-to-back items.
  task automatic put_word(input logic [31:0] w, input logic [2:0] nb, input logic last,
                          input bit steady, input logic pinned,
                          input logic [255:0] pinned_digest);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, nb, w};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hash_absorb(w, nb, last, pinned, pinned_digest);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every queued digest item has come back
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int r, j, len, msgs;
    bit steady;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    hash_restart();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      for (j = 0; j < DIR_TABLE[r].reps; j++) begin
        put_word(DIR_TABLE[r].word, DIR_TABLE[r].nbytes, DIR_TABLE[r].last, 1'b0,
                 DIR_TABLE[r].pinned, DIR_TABLE[r].digest);
      end
    end
    drain_digests();

    // Random messages; lengths cluster around the block padding boundary
    msgs = 0;
    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 35)      len = $urandom_range(0, 3);
      else if (r < 65) len = $urandom_range(4, 20);
      else if (r < 93) len = $urandom_range(12, 17);
      else             len = $urandom_range(30, 70);
      steady = ($urandom_range(0, 3) == 0);
      for (j = 0; j < len; j++) begin
        put_word($urandom, 3'($urandom_range(0, 7)), 1'b0, steady, 1'b0, '0);
      end
      put_word($urandom, 3'($urandom_range(0, 7)), 1'b1, steady, 1'b0, '0);
      msgs++;
      // once mid-run, let the pipeline empty completely
      if (msgs == 12) drain_digests();
      // receiver stalls hard while the sender keeps pushing
      if (items_sent >= DIR_ROWS + 60) start_long_hold = 1'b1;
    end

    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_sha256_hash OK");
    end else begin
      $display("tb_sha256_hash NOT OK");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    bit held;
    int run, stall;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (start_long_hold && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Digest checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest item with none expected", out_tdata, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word) report_mismatch("digest word", out_tdata, want.word);
        if (out_tlast !== want.last) begin
          report_mismatch("digest last flag", {31'b0, out_tlast}, {31'b0, want.last});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no handshake on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sha256_hash NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
